// File: rtl/amgs_pkg.sv
`timescale 1ns / 1ps

package amgs_pkg;

   localparam int MAX_NODES_DEF = 16;

   // depth of the command queue between front and back, a power of two
   localparam int QDEPTH = 2;

   // weight value that marks an absent edge
   localparam logic [15:0] NO_EDGE = 16'hFFFF;

   typedef enum logic {
      OP_NODE = 1'b0,
      OP_EDGE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_DUP      = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_MISSING  = 3'd4,
      ST_REPLACED = 3'd5
   } st_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SEARCH,
      BK_MREAD,
      BK_MCHK,
      BK_MWR2,
      BK_RESP
   } bk_state_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  origin;
      logic [7:0]  dest;
      logic [15:0] weight;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } bk_ctl_type;

endpackage

// File: rtl/amgs_if.sv
`timescale 1ns / 1ps

interface amgs_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [7:0]         origin_label;
   logic [7:0]         dest_label;
   logic signed [15:0] weight;

   modport source (
      output valid, req_type, origin_label, dest_label, weight,
      input  ready
   );
   modport sink (
      input  valid, req_type, origin_label, dest_label, weight,
      output ready
   );
endinterface

interface amgs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;

   modport source (
      output valid, status,
      input  ready
   );
   modport sink (
      input  valid, status,
      output ready
   );
endinterface

// File: rtl/adjacency_matrix_graph_store.sv
`timescale 1ns / 1ps

// the back end finishes one request word before it pops the next from the front-end queue
//    that buffers words meanwhile; the label search reads one entry a cycle, and both
//    symmetric matrix cells are written through the single matrix write port
// reset: synchronous; node count cleared, then a sweep writes no-edge to all MAX_NODES^2
//    matrix cells (256 by default) with req ready low

module adjacency_matrix_graph_store #(
   parameter int MAX_NODES = amgs_pkg::MAX_NODES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   amgs_req_if.sink      req_ch,
   amgs_rsp_if.source    rsp_ch
);
   import amgs_pkg::*;

   // queue head handed from the front end to the sequencer
   q_head_type q_head;
   // pop strobe and sweep-in-progress flag going back to the front end
   bk_ctl_type bk_ctl;

   // front end: takes request words, tags the operation, buffers them
   amgs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .bk_ctl (bk_ctl),
      .q_head (q_head)
   );

   // back end: label search, label append, matrix read of one cell and write of both
   // symmetric cells, and the registered response word
   amgs_back #(
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .bk_ctl (bk_ctl),
      .rsp_ch (rsp_ch)
   );

endmodule

// File: rtl/amgs_front.sv
`timescale 1ns / 1ps

module amgs_front (
   input  logic                   clock,
   input  logic                   reset,
   amgs_req_if.sink               req_ch,
   input  amgs_pkg::bk_ctl_type   bk_ctl,
   output amgs_pkg::q_head_type   q_head
);
   import amgs_pkg::*;

   localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   cmd_type          q_ff [QDEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]     cnt_ff, cnt_in;
   logic             push;
   logic             pop;
   cmd_type          cmd;

   always_comb begin
      cmd.op     = req_ch.req_type ? OP_EDGE : OP_NODE;
      cmd.origin = req_ch.origin_label;
      cmd.dest   = req_ch.dest_label;
      cmd.weight = req_ch.weight;

      // no new words while the matrix is being swept
      req_ch.ready = (cnt_ff != (QPW+1)'(QDEPTH)) && !bk_ctl.clearing;
      push         = req_ch.valid && req_ch.ready;
      pop          = bk_ctl.pop && (cnt_ff != '0);

      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase

      q_head.valid = (cnt_ff != '0);
      q_head.cmd   = q_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// File: rtl/amgs_back.sv
`timescale 1ns / 1ps

module amgs_back #(
   parameter int MAX_NODES = amgs_pkg::MAX_NODES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  amgs_pkg::q_head_type   q_head,
   output amgs_pkg::bk_ctl_type   bk_ctl,
   amgs_rsp_if.source             rsp_ch
);
   import amgs_pkg::*;

   localparam int IW    = $clog2(MAX_NODES);
   localparam int CW    = $clog2(MAX_NODES + 1);
   localparam int DEPTH = MAX_NODES * MAX_NODES;
   localparam int MW    = $clog2(DEPTH);

   bk_state_type    state_ff, state_in;
   cmd_type         cmd_ff, cmd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   issue_ff, issue_in;
   logic            cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]   cmp_idx_ff, cmp_idx_in;
   logic            found_o_ff, found_o_in;
   logic            found_d_ff, found_d_in;
   logic [IW-1:0]   pos_o_ff, pos_o_in;
   logic [IW-1:0]   pos_d_ff, pos_d_in;
   logic [MW-1:0]   clr_ff, clr_in;
   st_type          st_ff, st_in;
   logic            out_vld_ff, out_vld_in;
   st_type          out_st_ff, out_st_in;

   logic [7:0]      label_mem [MAX_NODES];
   logic [7:0]      lbl_rd_ff;
   logic            lbl_we;
   logic [IW-1:0]   lbl_waddr;
   logic [IW-1:0]   lbl_raddr;

   logic [15:0]     mat_mem [DEPTH];
   logic [15:0]     mat_rd_ff;
   logic            mat_we;
   logic [MW-1:0]   mat_waddr;
   logic [MW-1:0]   mat_raddr;
   logic [15:0]     mat_wdata;

   logic [MW-1:0]   addr_a;
   logic [MW-1:0]   addr_b;
   logic            hit_o;
   logic            hit_d;
   logic            exhausted;
   logic            pop;

   always_comb begin
      addr_a = MW'(pos_o_ff) * MW'(MAX_NODES) + MW'(pos_d_ff);
      addr_b = MW'(pos_d_ff) * MW'(MAX_NODES) + MW'(pos_o_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_CLEAR;
         count_ff   <= '0;
         clr_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         found_o_ff <= 1'b0;
         found_d_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         clr_ff     <= clr_in;
         cmp_vld_ff <= cmp_vld_in;
         found_o_ff <= found_o_in;
         found_d_ff <= found_d_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      pos_o_ff   <= pos_o_in;
      pos_d_ff   <= pos_d_in;
      st_ff      <= st_in;
      out_st_ff  <= out_st_in;
   end

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         label_mem[lbl_waddr] <= cmd_ff.origin;
      end
      lbl_rd_ff <= label_mem[lbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_waddr] <= mat_wdata;
      end
      mat_rd_ff <= mat_mem[mat_raddr];
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      issue_in   = issue_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      found_o_in = found_o_ff;
      found_d_in = found_d_ff;
      pos_o_in   = pos_o_ff;
      pos_d_in   = pos_d_ff;
      clr_in     = clr_ff;
      st_in      = st_ff;
      out_st_in  = out_st_ff;
      out_vld_in = out_vld_ff && !rsp_ch.ready;
      pop        = 1'b0;
      lbl_we     = 1'b0;
      lbl_waddr  = count_ff[IW-1:0];
      lbl_raddr  = issue_ff[IW-1:0];
      mat_we     = 1'b0;
      mat_waddr  = addr_a;
      mat_raddr  = addr_a;
      mat_wdata  = cmd_ff.weight;

      hit_o     = cmp_vld_ff && (lbl_rd_ff == cmd_ff.origin) && !found_o_ff;
      hit_d     = cmp_vld_ff && (lbl_rd_ff == cmd_ff.dest) && !found_d_ff;
      exhausted = (issue_ff == count_ff);

      case (state_ff)
         BK_CLEAR: begin
            mat_we    = 1'b1;
            mat_waddr = clr_ff;
            mat_wdata = NO_EDGE;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == MW'(DEPTH - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_head.valid) begin
               pop        = 1'b1;
               cmd_in     = q_head.cmd;
               issue_in   = '0;
               cmp_vld_in = 1'b0;
               found_o_in = 1'b0;
               found_d_in = 1'b0;
               if (q_head.cmd.op == OP_NODE && count_ff == CW'(MAX_NODES)) begin
                  st_in    = ST_FULL;
                  state_in = BK_RESP;
               end else if (q_head.cmd.op == OP_EDGE && count_ff == '0) begin
                  st_in    = ST_EMPTY;
                  state_in = BK_RESP;
               end else begin
                  state_in = BK_SEARCH;
               end
            end
         end
         BK_SEARCH: begin
            // issue one table read and compare the previous one each cycle
            cmp_vld_in = !exhausted;
            cmp_idx_in = issue_ff[IW-1:0];
            if (!exhausted) begin
               issue_in = issue_ff + 1'b1;
            end
            if (hit_o) begin
               found_o_in = 1'b1;
               pos_o_in   = cmp_idx_ff;
            end
            if (hit_d) begin
               found_d_in = 1'b1;
               pos_d_in   = cmp_idx_ff;
            end
            if (cmd_ff.op == OP_NODE) begin
               if (found_o_in) begin
                  st_in    = ST_DUP;
                  state_in = BK_RESP;
               end else if (exhausted) begin
                  lbl_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  st_in    = ST_OK;
                  state_in = BK_RESP;
               end
            end else begin
               if (found_o_in && found_d_in) begin
                  state_in = BK_MREAD;
               end else if (exhausted) begin
                  st_in    = ST_MISSING;
                  state_in = BK_RESP;
               end
            end
         end
         BK_MREAD: begin
            state_in = BK_MCHK;
         end
         BK_MCHK: begin
            st_in    = (mat_rd_ff != NO_EDGE) ? ST_REPLACED : ST_OK;
            mat_we   = 1'b1;
            state_in = BK_MWR2;
         end
         BK_MWR2: begin
            mat_we    = 1'b1;
            mat_waddr = addr_b;
            state_in  = BK_RESP;
         end
         BK_RESP: begin
            if (!out_vld_ff || rsp_ch.ready) begin
               out_vld_in = 1'b1;
               out_st_in  = st_ff;
               state_in   = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign bk_ctl.pop      = pop;
   assign bk_ctl.clearing = (state_ff == BK_CLEAR);
   assign rsp_ch.valid    = out_vld_ff;
   assign rsp_ch.status   = out_st_ff;

endmodule

// File: rtl/amgs_checker.sv
`timescale 1ns / 1ps

module amgs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status
);
   import amgs_pkg::*;

   // words accepted but not yet answered
   logic [2:0] outst_ff, outst_in;
   logic       req_acc;
   logic       rsp_acc;

   always_comb begin
      req_acc = req_valid && req_ready;
      rsp_acc = rsp_valid && rsp_ready;
      case ({req_acc, rsp_acc})
         2'b10:   outst_in = outst_ff + 1'b1;
         2'b01:   outst_in = outst_ff - 1'b1;
         default: outst_in = outst_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   a_sweep_blocks_req: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during matrix sweep");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response present right after reset");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outst_ff != 3'd0))
      else $error("response without an outstanding request");

   a_outst_bound: assert property (@(posedge clock) disable iff (reset)
      outst_ff <= 3'(QDEPTH + 2))
      else $error("more words in flight than the buffering allows");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind adjacency_matrix_graph_store amgs_checker u_amgs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status)
);
